@@ hw/rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Fixed widths of the request and result fields.
    localparam int COORD_W          = 16;
    localparam int INDEX_W          = 4;
    localparam int COUNT_CFG_W      = 5;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 8;
    localparam int DEF_MAX_VERTICES = 16;

    // Request kind carried on the input tuser.
    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    // Controller states.
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_DRAIN
    } pip_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic wr_en;        // store the request's vertex
        logic start;        // latch the query point and clear the flag
        logic rd_en;        // read one vertex from the table
        logic rd_edge;      // the vertex read closes an edge with the previous one
        logic load_result;  // copy the flag into the result register
    } pip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic busy;         // edge pipeline still holds work
    } pip_sts_t;

endpackage : pip_pkg
`default_nettype wire

@@ hw/rtl/pip_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex table and edge crossing pipeline of the point-in-polygon test.
// ----------------------------------------------------------------------------
module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int ADDR_W       = $clog2(MAX_VERTICES)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pip_cmd_t                  cmd,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    input  wire logic [INDEX_W-1:0]        vertex_index,
    input  wire logic signed [COORD_W-1:0] vertex_x,
    input  wire logic signed [COORD_W-1:0] vertex_y,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    output pip_sts_t                       sts,
    output logic                           inside_res
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CMP_W  = PROD_W + 1;

    // Vertex table, y in the upper half of each word.
    logic [2*COORD_W-1:0] mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 wr_ok;

    logic                     rd_valid_reg;
    logic                     rd_edge_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [COORD_W-1:0] xj_reg;
    logic signed [COORD_W-1:0] yj_reg;
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] yi;

    logic signed [DIFF_W-1:0] dxp_reg, dxp_next;
    logic signed [DIFF_W-1:0] dy_reg, dy_next;
    logic signed [DIFF_W-1:0] dxe_reg, dxe_next;
    logic signed [DIFF_W-1:0] dyp_reg, dyp_next;
    logic                     v1_reg, v1_next;
    logic                     straddle1_reg, straddle1_next;
    logic                     dpos1_reg, dpos1_next;

    logic signed [PROD_W-1:0] lprod_reg, lprod_next;
    logic signed [PROD_W-1:0] rprod_reg, rprod_next;
    logic                     v2_reg;
    logic                     straddle2_reg;
    logic                     dpos2_reg;

    logic signed [CMP_W-1:0] diff;
    logic                    diff_neg;
    logic                    diff_zero;
    logic                    left;
    logic                    inside_reg, inside_next;
    logic                    result_reg;

    assign wr_ok = (32'(vertex_index) < 32'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[ADDR_W'(vertex_index)] <= {vertex_y, vertex_x};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign xi = rd_data_reg[COORD_W-1:0];
    assign yi = rd_data_reg[2*COORD_W-1:COORD_W];

    // Stage one: differences and the straddle test of edge (current, previous).
    always_comb
    begin
        dxp_next       = DIFF_W'(px_reg) - DIFF_W'(xi);
        dy_next        = DIFF_W'(yj_reg) - DIFF_W'(yi);
        dxe_next       = DIFF_W'(xj_reg) - DIFF_W'(xi);
        dyp_next       = DIFF_W'(py_reg) - DIFF_W'(yi);
        straddle1_next = (yi > py_reg) != (yj_reg > py_reg);
        dpos1_next     = (yj_reg > yi);
        v1_next        = rd_valid_reg && rd_edge_reg;
    end

    // Stage two: the two cross products.
    always_comb
    begin
        lprod_next = dxp_reg * dy_reg;
        rprod_next = dxe_reg * dyp_reg;
    end

    // Stage three: sign of the difference decides the side.
    always_comb
    begin
        diff      = CMP_W'(lprod_reg) - CMP_W'(rprod_reg);
        diff_neg  = diff[CMP_W-1];
        diff_zero = (diff == '0);
        left      = dpos2_reg ? diff_neg : (!diff_neg && !diff_zero);
        if (cmd.start)
        begin
            inside_next = 1'b0;
        end
        else if (v2_reg && straddle2_reg && left)
        begin
            inside_next = !inside_reg;
        end
        else
        begin
            inside_next = inside_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (rd_valid_reg)
        begin
            xj_reg <= xi;
            yj_reg <= yi;
        end
        rd_edge_reg   <= cmd.rd_edge;
        dxp_reg       <= dxp_next;
        dy_reg        <= dy_next;
        dxe_reg       <= dxe_next;
        dyp_reg       <= dyp_next;
        straddle1_reg <= straddle1_next;
        dpos1_reg     <= dpos1_next;
        lprod_reg     <= lprod_next;
        rprod_reg     <= rprod_next;
        straddle2_reg <= straddle1_reg;
        dpos2_reg     <= dpos1_reg;
        if (cmd.load_result)
        begin
            result_reg <= inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            v1_reg       <= v1_next;
            v2_reg       <= v1_reg;
            inside_reg   <= inside_next;
        end
    end

    assign sts.busy   = rd_valid_reg || v1_reg || v2_reg;
    assign inside_res = result_reg;

`ifndef ASSERT_OFF
    // An edge enters the product stage only in the cycle after a table read.
    a_v1_after_read : assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> $past(rd_valid_reg))
        else $error("edge stage valid without a preceding read");

    // The flag is never toggled while a new query is being started.
    a_no_toggle_at_start : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !v2_reg)
        else $error("query started while edges still in flight");

    // The result register is loaded only once the pipeline has drained.
    a_load_drained : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !sts.busy)
        else $error("result loaded with edges still in flight");
`endif

endmodule : pip_datapath
`default_nettype wire

@@ hw/rtl/pip_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer of the point-in-polygon test: request handshake, vertex walk,
// result register handshake and the vertex count register.
// ----------------------------------------------------------------------------
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int ADDR_W       = $clog2(MAX_VERTICES)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_CFG_W-1:0] cfg_wr_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire pip_sts_t               sts,
    output pip_cmd_t                    cmd,
    output logic [ADDR_W-1:0]           rd_addr
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    pip_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              is_query;
    logic              last_vertex;

    assign accept      = s_tvalid && s_tready;
    assign is_query    = (s_tuser == REQ_QUERY);
    assign last_vertex = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && is_query)
                begin
                    state_next = (count_reg == '0) ? ST_DRAIN : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                idx_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (last_vertex)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy && (!out_valid_reg || m_tready))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        rd_addr  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.wr_en = s_tvalid && !is_query;
                cmd.start = s_tvalid && is_query;
            end
            ST_PRIME:
            begin
                cmd.rd_en = 1'b1;
                rd_addr   = ADDR_W'(count_reg - CNT_W'(1));
            end
            ST_WALK:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_edge = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.load_result = !sts.busy && (!out_valid_reg || m_tready);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // A count above the table size saturates.
    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr_en)
        begin
            if (32'(cfg_wr_data) > 32'(MAX_VERTICES))
            begin
                count_next = CNT_W'(MAX_VERTICES);
            end
            else
            begin
                count_next = CNT_W'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    // A query holds off further requests in the cycle after it is accepted.
    a_query_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_query) |=> !s_tready)
        else $error("request taken right after a query");

    // Every table read stays below the vertex count.
    a_read_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (CNT_W'(rd_addr) < count_reg))
        else $error("vertex read beyond the vertex count");

    // Requests are taken only with an empty edge pipeline.
    a_accept_idle_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !sts.busy)
        else $error("request taken while edges still in flight");

    // A waiting result is never overwritten.
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule : pip_ctrl
`default_nettype wire

@@ hw/rtl/point_in_polygon_test_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Even-odd ray casting point-in-polygon test over a stored polygon.
// ----------------------------------------------------------------------------
// The block holds a polygon of up to MAX_VERTICES vertices in signed Q1.15
// and answers whether a query point lies inside it by the even-odd rule.
// A write request (tuser 0) stores one vertex at vertex_index and gives no
// result; an index at or above MAX_VERTICES is dropped. A query request
// (tuser 1) gives exactly one result, inside_res in bit 0 of the output
// tdata. The query first reads the closing vertex from the vertex table,
// then reads each vertex in turn and forms one edge with the one before
// it, and the edge test runs through a three-stage difference, multiply
// and compare pipeline that must drain before the flag is final and the
// next request is taken. With a vertex count of zero the answer is
// outside. The vertex count register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as
// the block does not enforce it. A value above MAX_VERTICES acts as
// MAX_VERTICES. The edge test is exact: the crossing comparison uses
// cross products instead of a division. Every vertex below the vertex
// count must be written before a query reads it. A finished result waits
// in an output register, and the block takes the next request while it
// waits; a second query then holds in its last step, and stalls the
// request input, until the waiting result is taken.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Vertex count register write.
    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_CFG_W-1:0] cfg_wr_data,
    // Request stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // From bit 0: vertex_index[3:0], vertex_x[19:4], vertex_y[35:20],
    // point_x[51:36], point_y[67:52], zero fill[71:68].
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // Bit 0: req_type.
    input  wire logic                   s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // From bit 0: inside_res[0], zero fill[7:1].
    output logic [M_TDATA_W-1:0]        m_tdata
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);

    localparam int VX_LO = INDEX_W;
    localparam int VY_LO = VX_LO + COORD_W;
    localparam int PX_LO = VY_LO + COORD_W;
    localparam int PY_LO = PX_LO + COORD_W;

    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      inside_res;

    pip_cmd_t          cmd;
    pip_sts_t          sts;
    logic [ADDR_W-1:0] rd_addr;

    // Unpack the request fields.
    assign vertex_index = s_tdata[INDEX_W-1:0];
    assign vertex_x     = s_tdata[VX_LO +: COORD_W];
    assign vertex_y     = s_tdata[VY_LO +: COORD_W];
    assign point_x      = s_tdata[PX_LO +: COORD_W];
    assign point_y      = s_tdata[PY_LO +: COORD_W];

    // The controller sequences the walk over the table; the datapath owns
    // the table, the edge pipeline and the result register.
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .sts         (sts),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .vertex_index (vertex_index),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .point_x      (point_x),
        .point_y      (point_y),
        .sts          (sts),
        .inside_res   (inside_res)
    );

    // Pack the result; the upper bits are zero fill.
    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, inside_res};

endmodule : point_in_polygon_test_top
`default_nettype wire
